### hdl/rau_pkg.sv
// Shared types, codes and widths for the rational arithmetic unit.
package rau_pkg;

  // Operand word width; intermediates are twice as wide.
  localparam int WORD_BITS = 32;
  localparam int MAG_W     = WORD_BITS;
  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int SHIFT_W   = $clog2(PROD_W);
  localparam int CNT_W     = $clog2(PROD_W);

  // Command codes.
  localparam logic [2:0] CMD_MAKE = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;
  } out_word_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_IDLE, DP_LOAD, DP_MUL0, DP_MUL1, DP_MUL2, DP_SUM,
    DP_GCD, DP_GEND, DP_DIV, DP_DDEN_INIT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MUL0, S_MUL1, S_MUL2, S_SUM, S_ZTEST,
    S_GCD, S_GEND, S_DNUM, S_DDEN_INIT, S_DDEN, S_FIN
  } state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] fin_err;
    logic       fin_zero;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] chk_err;
    logic       arith;
    logic       num_zero;
    logic       gcd_done;
  } dp_stat_t;

endpackage

### hdl/rau_ctrl.sv
// Controller state machine sequencing the rational arithmetic datapath.
module rau_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_free,
  input  rau_pkg::dp_stat_t stat,
  output rau_pkg::ctl_cmd_t cmd,
  output logic              busy,
  output logic              load_out
);
  import rau_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       fin_err, fin_err_next;
  logic             fin_zero, fin_zero_next;
  logic             cnt_last;

  assign cnt_last = (cnt == CNT_W'(PROD_W - 1));

  // State, step counter and pending result kind.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      fin_err  <= ST_OK;
      fin_zero <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      fin_err  <= fin_err_next;
      fin_zero <= fin_zero_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    fin_err_next  = fin_err;
    fin_zero_next = fin_zero;
    cmd.op        = DP_IDLE;
    cmd.fin_err   = fin_err;
    cmd.fin_zero  = fin_zero;
    busy          = 1'b1;
    load_out      = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (in_valid) begin
          cmd.op        = DP_LOAD;
          fin_err_next  = ST_OK;
          fin_zero_next = 1'b0;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.chk_err != ST_OK) begin
          fin_err_next = stat.chk_err;
          state_next   = S_FIN;
        end else if (stat.arith) begin
          state_next = S_MUL0;
        end else begin
          state_next = S_SUM;
        end
      end
      S_MUL0: begin
        cmd.op     = DP_MUL0;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.op     = DP_MUL1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.op     = DP_MUL2;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op     = DP_SUM;
        state_next = S_ZTEST;
      end
      S_ZTEST: begin
        if (stat.num_zero) begin
          fin_zero_next = 1'b1;
          state_next    = S_FIN;
        end else begin
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        cmd.op = DP_GCD;
        if (stat.gcd_done) state_next = S_GEND;
      end
      S_GEND: begin
        cmd.op     = DP_GEND;
        cnt_next   = '0;
        state_next = S_DNUM;
      end
      S_DNUM: begin
        cmd.op   = DP_DIV;
        cnt_next = cnt + 1'b1;
        if (cnt_last) state_next = S_DDEN_INIT;
      end
      S_DDEN_INIT: begin
        cmd.op     = DP_DDEN_INIT;
        cnt_next   = '0;
        state_next = S_DDEN;
      end
      S_DDEN: begin
        cmd.op   = DP_DIV;
        cnt_next = cnt + 1'b1;
        if (cnt_last) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### hdl/rau_dpath.sv
// Datapath: sign-magnitude operands, shared multiplier, binary gcd and serial divider.
module rau_dpath (
  input  logic               clk,
  input  rau_pkg::in_word_t  in_data,
  input  rau_pkg::ctl_cmd_t  cmd,
  output rau_pkg::dp_stat_t  stat,
  output rau_pkg::out_word_t result
);
  import rau_pkg::*;

  localparam logic [PROD_W-1:0] LIM = PROD_W'(1) << (WORD_BITS - 1);

  logic [2:0]         op_cmd;
  logic               an_neg, ad_neg, bn_neg, bd_neg;
  logic [MAG_W-1:0]   an_mag, ad_mag, bn_mag, bd_mag;
  logic [PROD_W-1:0]  pa_mag, pb_mag, pc_mag;
  logic               pa_neg, pb_neg, pc_neg;
  logic [PROD_W-1:0]  num_mag, den_mag;
  logic               num_neg, den_neg;
  logic [PROD_W-1:0]  x, y, rem, quo, nq;
  logic [SHIFT_W-1:0] k;
  logic [PROD_W-1:0]  g;

  logic [MAG_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  sum_mag;
  logic               sum_neg;
  logic [PROD_W:0]    div_sh;
  logic               div_ge;
  logic               is_arith, res_neg, ovf;
  logic [63:0]        nm_ext, dm_ext, val_ext;

  // Two's complement operand to sign and magnitude.
  function automatic logic [MAG_W:0] to_smag(input logic [31:0] raw);
    logic [MAG_W-1:0] m;
    m = raw[MAG_W-1:0];
    return m[MAG_W-1] ? {1'b1, (~m) + 1'b1} : {1'b0, m};
  endfunction

  assign is_arith = (op_cmd == CMD_ADD) || (op_cmd == CMD_SUB) ||
                    (op_cmd == CMD_MUL) || (op_cmd == CMD_DIV);

  // Operand checks for the error statuses, and the other status flags for the controller.
  always_comb begin
    stat.arith    = is_arith;
    stat.num_zero = (num_mag == '0);
    stat.gcd_done = (x == y);
    if (ad_mag == '0 || (is_arith && bd_mag == '0)) stat.chk_err = ST_ZDEN;
    else if (op_cmd == CMD_DIV && bn_mag == '0)      stat.chk_err = ST_DIVZ;
    else                                             stat.chk_err = ST_OK;
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = an_mag;
    mul_b = bd_mag;
    case (cmd.op)
      DP_MUL0: begin
        mul_a = an_mag;
        mul_b = (op_cmd == CMD_MUL) ? bn_mag : bd_mag;
      end
      DP_MUL1: begin
        mul_a = bn_mag;
        mul_b = ad_mag;
      end
      DP_MUL2: begin
        mul_a = ad_mag;
        mul_b = (op_cmd == CMD_DIV) ? bn_mag : bd_mag;
      end
      default: ;
    endcase
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Signed magnitude sum of the two cross products.
  always_comb begin
    if (pa_neg == pb_neg) begin
      sum_mag = pa_mag + pb_mag;
      sum_neg = pa_neg;
    end else if (pa_mag >= pb_mag) begin
      sum_mag = pa_mag - pb_mag;
      sum_neg = pa_neg;
    end else begin
      sum_mag = pb_mag - pa_mag;
      sum_neg = pb_neg;
    end
  end

  // One restoring division step.
  assign div_sh = {rem, quo[PROD_W-1]};
  assign div_ge = (div_sh >= {1'b0, g});

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        op_cmd           <= in_data.cmd;
        {an_neg, an_mag} <= to_smag(in_data.a_num);
        {ad_neg, ad_mag} <= to_smag(in_data.a_den);
        {bn_neg, bn_mag} <= to_smag(in_data.b_num);
        {bd_neg, bd_mag} <= to_smag(in_data.b_den);
      end
      DP_MUL0: begin
        pa_mag <= prod;
        pa_neg <= an_neg ^ ((op_cmd == CMD_MUL) ? bn_neg : bd_neg);
      end
      DP_MUL1: begin
        pb_mag <= prod;
        pb_neg <= (bn_neg ^ (op_cmd == CMD_SUB)) ^ ad_neg;
      end
      DP_MUL2: begin
        pc_mag <= prod;
        pc_neg <= ad_neg ^ ((op_cmd == CMD_DIV) ? bn_neg : bd_neg);
      end
      DP_SUM: begin
        k <= '0;
        if (is_arith) begin
          if (op_cmd == CMD_ADD || op_cmd == CMD_SUB) begin
            num_mag <= sum_mag;
            num_neg <= sum_neg;
            x       <= sum_mag;
          end else begin
            num_mag <= pa_mag;
            num_neg <= pa_neg;
            x       <= pa_mag;
          end
          den_mag <= pc_mag;
          den_neg <= pc_neg;
          y       <= pc_mag;
        end else begin
          num_mag <= PROD_W'(an_mag);
          num_neg <= an_neg;
          x       <= PROD_W'(an_mag);
          den_mag <= PROD_W'(ad_mag);
          den_neg <= ad_neg;
          y       <= PROD_W'(ad_mag);
        end
      end
      DP_GCD: begin
        // Binary gcd: strip common twos, then odd differences.
        if (x != y) begin
          if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + 1'b1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x > y) begin
            x <= x - y;
          end else begin
            y <= y - x;
          end
        end
      end
      DP_GEND: begin
        g   <= x << k;
        rem <= '0;
        quo <= num_mag;
      end
      DP_DIV: begin
        if (div_ge) rem <= PROD_W'(div_sh - {1'b0, g});
        else        rem <= div_sh[PROD_W-1:0];
        quo <= {quo[PROD_W-2:0], div_ge};
      end
      DP_DDEN_INIT: begin
        nq  <= quo;
        rem <= '0;
        quo <= den_mag;
      end
      default: ;
    endcase
  end

  // Result word: reduced fraction, zero value or error.
  always_comb begin
    res_neg = num_neg ^ den_neg;
    ovf     = (quo >= LIM) || (res_neg ? (nq > LIM) : (nq >= LIM));
    nm_ext  = 64'(nq);
    dm_ext  = 64'(quo);
    val_ext = res_neg ? (64'd0 - nm_ext) : nm_ext;
    if (cmd.fin_err != ST_OK) begin
      result.res_num = '0;
      result.res_den = '0;
      result.status  = cmd.fin_err;
    end else if (cmd.fin_zero) begin
      result.res_num = '0;
      result.res_den = 31'd1;
      result.status  = ST_OK;
    end else if (ovf) begin
      result.res_num = '0;
      result.res_den = '0;
      result.status  = ST_OVF;
    end else begin
      result.res_num = val_ext[31:0];
      result.res_den = dm_ext[30:0];
      result.status  = ST_OK;
    end
  end

endmodule

### hdl/rational_arith_unit.sv
// Top level of the rational arithmetic unit: controller, datapath and output register.
// A taken word is checked; an error goes straight to the result. Arithmetic commands form three
// cross products; then a sum and zero test, and a nonzero value runs binary gcd and two divisions.
// Throughput: one word at a time; a new word is taken the cycle after the result enters the
// output register, which waits while a previous result is stalled. Reset (rst, synchronous)
// returns the controller to idle and empties the output register.
module rational_arith_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rau_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rau_pkg::out_word_t out_data
);
  import rau_pkg::*;

  ctl_cmd_t  cmd;
  dp_stat_t  stat;
  out_word_t result;
  logic      busy, load_out, out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = busy;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .load_out (load_out)
  );

  rau_dpath u_dpath (
    .clk     (clk),
    .in_data (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_data <= result;
  end

endmodule

### hdl/rau_checker.sv
// Port-level checks for the rational arithmetic unit, bound to the top level.
module rau_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input rau_pkg::out_word_t out_data,
  input logic               out_valid,
  input logic               out_stall
);
  import rau_pkg::*;

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // The unit is busy in the cycle after taking a word.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word was in progress");

  // Errors carry a zero fraction.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.res_num == '0 &&
      out_data.res_den == '0)
    else $error("error result with nonzero fraction");

  // Good results have a positive denominator, one for a zero value.
  a_ok_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_OK |-> out_data.res_den != '0 &&
      (out_data.res_num != '0 || out_data.res_den == 31'd1))
    else $error("bad denominator on good result");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
